// ----- src/hla_pkg.sv -----
package hla_pkg;

  localparam int PERIOD_W = 16;
  localparam int LCM_W    = 31;
  localparam int PROD_W   = LCM_W + PERIOD_W;
  localparam int PC_W     = 4;
  localparam int CNT_W    = $clog2(LCM_W + 1);

  localparam logic [LCM_W-1:0] LCM_MAX = {LCM_W{1'b1}};
  localparam logic [LCM_W-1:0] LCM_ONE = {{(LCM_W-1){1'b0}}, 1'b1};

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_NO_REQ,
    C_X_ZERO,
    C_Y_ZERO,
    C_G_ZERO,
    C_DIV_BUSY,
    C_RSP_FULL
  } cond_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,
    A_G_Y,
    A_G_X,
    A_DIV_YX,
    A_DIV_XY,
    A_DIV_CG,
    A_WR_Y,
    A_WR_X,
    A_WR_Q,
    A_MUL,
    A_STORE
  } act_t;

  typedef struct packed {
    cond_t cond;
    act_t  act;
    pc_t   target;
  } ucode_t;

  localparam pc_t PC_LOAD   = 4'd0;
  localparam pc_t PC_TEST_X = 4'd1;
  localparam pc_t PC_WAIT_Y = 4'd3;
  localparam pc_t PC_WAIT_X = 4'd6;
  localparam pc_t PC_GCD    = 4'd8;
  localparam pc_t PC_WAIT_Q = 4'd9;
  localparam pc_t PC_OUT    = 4'd11;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      4'd0:    w = '{C_NO_REQ,   A_LOAD,   PC_LOAD};
      4'd1:    w = '{C_X_ZERO,   A_G_Y,    PC_GCD};
      4'd2:    w = '{C_NEXT,     A_DIV_YX, PC_LOAD};
      4'd3:    w = '{C_DIV_BUSY, A_WR_Y,   PC_WAIT_Y};
      4'd4:    w = '{C_Y_ZERO,   A_G_X,    PC_GCD};
      4'd5:    w = '{C_NEXT,     A_DIV_XY, PC_LOAD};
      4'd6:    w = '{C_DIV_BUSY, A_WR_X,   PC_WAIT_X};
      4'd7:    w = '{C_JUMP,     A_NONE,   PC_TEST_X};
      4'd8:    w = '{C_G_ZERO,   A_DIV_CG, PC_OUT};
      4'd9:    w = '{C_DIV_BUSY, A_WR_Q,   PC_WAIT_Q};
      4'd10:   w = '{C_NEXT,     A_MUL,    PC_LOAD};
      4'd11:   w = '{C_RSP_FULL, A_NONE,   PC_OUT};
      4'd12:   w = '{C_JUMP,     A_STORE,  PC_LOAD};
      default: w = '{C_JUMP,     A_NONE,   PC_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ----- src/hla_if.sv -----
interface hla_req_if;
  logic                          valid;
  logic                          ready;
  logic [hla_pkg::PERIOD_W-1:0]  period;
  logic                          last;

  modport source (output valid, period, last, input ready);
  modport sink   (input valid, period, last, output ready);
endinterface

interface hla_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hla_pkg::LCM_W-1:0]     hyperperiod;
  logic                          overflow;
  logic                          set_done;

  modport source (output valid, hyperperiod, overflow, set_done, input ready);
  modport sink   (input valid, hyperperiod, overflow, set_done, output ready);
endinterface

// ----- src/hyperperiod_lcm_accumulator.sv -----
// Running least common multiple of task periods (hyperperiod).
// req carries one period and a last flag per request; rsp returns one
// result per request: the hyperperiod so far (saturated at 2^31-1), a
// sticky overflow flag and set_done, which echoes last.
// The accumulator starts at 1; after a request marked last it returns to 1
// and the overflow flag clears. A zero period drives the value to zero.
// One request is in work at a time; req.ready is high only while the
// sequencer waits in its load step. The gcd is Euclid's remainder loop on a
// restoring divider that retires one quotient bit per cycle, and the same
// divider forms running / gcd before a single 31x16 multiply.
// The result sits in an output register; while rsp is stalled the
// sequencer holds before writing it, so no result is lost.
// rst (synchronous) sets the value to 1, clears the flag, empties the
// output register and returns the sequencer to its load step.
module hyperperiod_lcm_accumulator (
  input  logic       clk,
  input  logic       rst,
  hla_req_if.sink    req,
  hla_rsp_if.source  rsp
);
  import hla_pkg::*;

  pc_t                pc;
  pc_t                pc_next;
  ucode_t             uw;

  logic [LCM_W-1:0]    running;
  logic                ovf;
  logic [LCM_W-1:0]    x;
  logic [LCM_W-1:0]    y;
  logic [LCM_W-1:0]    g;
  logic [LCM_W-1:0]    quo;
  logic [PERIOD_W-1:0] per;
  logic                last_r;
  logic [PROD_W-1:0]   prod;

  logic                div_start;
  logic [LCM_W-1:0]    div_n;
  logic [LCM_W-1:0]    div_d;
  logic [LCM_W-1:0]    div_d_r;
  logic [LCM_W-1:0]    div_r;
  logic [LCM_W-1:0]    div_q;
  logic [CNT_W-1:0]    div_cnt;
  logic                div_busy;
  logic [LCM_W:0]      div_sh;

  logic                sat;
  logic [LCM_W-1:0]    clamped;
  logic                out_valid;
  logic                take;

  assign uw       = ucode_rom(pc);
  assign req.ready = (pc == PC_LOAD);
  assign take     = req.valid && req.ready;
  assign div_busy = (div_cnt != '0);

  always_comb begin
    pc_next = pc + 1'b1;
    case (uw.cond)
      C_NEXT:     pc_next = pc + 1'b1;
      C_JUMP:     pc_next = uw.target;
      C_NO_REQ:   if (!req.valid) pc_next = uw.target;
      C_X_ZERO:   if (x == '0) pc_next = uw.target;
      C_Y_ZERO:   if (y == '0) pc_next = uw.target;
      C_G_ZERO:   if (g == '0) pc_next = uw.target;
      C_DIV_BUSY: if (div_busy) pc_next = uw.target;
      C_RSP_FULL: if (out_valid) pc_next = uw.target;
      default:    pc_next = PC_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_n     = y;
    div_d     = x;
    case (uw.act)
      A_DIV_YX: begin
        div_start = 1'b1;
        div_n     = y;
        div_d     = x;
      end
      A_DIV_XY: begin
        div_start = 1'b1;
        div_n     = x;
        div_d     = y;
      end
      A_DIV_CG: begin
        div_start = 1'b1;
        div_n     = running;
        div_d     = g;
      end
      default: div_start = 1'b0;
    endcase
  end

  // restoring divider, one quotient bit per cycle
  assign div_sh = {div_r, div_q[LCM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_start) begin
      div_cnt <= CNT_W'(LCM_W);
    end else if (div_busy) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_r <= '0;
      div_q <= div_n;
      div_d_r <= div_d;
    end else if (div_busy) begin
      if (div_sh >= {1'b0, div_d_r}) begin
        div_r <= LCM_W'(div_sh - {1'b0, div_d_r});
        div_q <= {div_q[LCM_W-2:0], 1'b1};
      end else begin
        div_r <= div_sh[LCM_W-1:0];
        div_q <= {div_q[LCM_W-2:0], 1'b0};
      end
    end
  end

  assign sat     = (prod > PROD_W'(LCM_MAX));
  assign clamped = sat ? LCM_MAX : prod[LCM_W-1:0];

  always_ff @(posedge clk) begin
    case (uw.act)
      A_LOAD: begin
        if (take) begin
          x      <= running;
          y      <= LCM_W'(req.period);
          per    <= req.period;
          last_r <= req.last;
        end
      end
      A_G_Y:    g    <= y;
      A_G_X:    g    <= x;
      A_WR_Y:   y    <= div_r;
      A_WR_X:   x    <= div_r;
      A_WR_Q:   quo  <= div_q;
      A_DIV_CG: prod <= '0;
      A_MUL:    prod <= PROD_W'(quo) * PROD_W'(per);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= LCM_ONE;
      ovf     <= 1'b0;
    end else if (uw.act == A_STORE) begin
      running <= last_r ? LCM_ONE : clamped;
      ovf     <= last_r ? 1'b0 : (ovf | sat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.act == A_STORE) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.act == A_STORE) begin
      rsp.hyperperiod <= clamped;
      rsp.overflow    <= ovf | sat;
      rsp.set_done    <= last_r;
    end
  end

  assign rsp.valid = out_valid;

endmodule
